@@ rtl/core/s2fe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Steim2 frame encoder package
// Shared types, constants and helper functions for the Steim2 frame encoder.
// ----------------------------------------------------------------------------
package s2fe_pkg;

	localparam int FRAME_WORDS  = 16;
	localparam int WINDOW_DIFFS = 7;
	localparam int OUTQ_DEPTH   = 4;
	localparam int SLOT_W       = $clog2(FRAME_WORDS);
	localparam int CNT_W        = $clog2(WINDOW_DIFFS + 1);
	localparam int OUTQ_PTR_W   = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W   = $clog2(OUTQ_DEPTH + 1);

	// Input opcodes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	// Two-bit nibble codes gathered into W0.
	localparam logic [1:0] NIB_NONE  = 2'd0;
	localparam logic [1:0] NIB_4X8   = 2'd1;
	localparam logic [1:0] NIB_DNIB  = 2'd2;
	localparam logic [1:0] NIB_SMALL = 2'd3;

	// Packing classes, from narrowest to widest difference.
	typedef enum logic [2:0] {
		PK_7X4, PK_6X5, PK_5X6, PK_4X8, PK_3X10, PK_2X15, PK_1X30
	} pack_class_t;

	// Magnitude limits of each class.
	localparam logic [31:0] LIM_7X4  = 32'd7;
	localparam logic [31:0] LIM_6X5  = 32'd15;
	localparam logic [31:0] LIM_5X6  = 32'd31;
	localparam logic [31:0] LIM_4X8  = 32'd127;
	localparam logic [31:0] LIM_3X10 = 32'd511;
	localparam logic [31:0] LIM_2X15 = 32'd16383;

	typedef enum logic [1:0] {ST_IDLE, ST_PACK, ST_EMIT} state_t;

	typedef logic [WINDOW_DIFFS-1:0][31:0] diff_win_t;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] sample;
		logic               start_record;
	} in_item_t;

	typedef struct packed {
		logic [31:0]       word;
		logic [SLOT_W-1:0] word_index;
		logic              last_of_frame;
		logic              last_of_record;
	} out_item_t;

	// Reverse the byte order of a word.
	function automatic logic [31:0] byte_rev(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/s2fe_pack.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Steim2 word packer
// Picks the packing class from the largest magnitude in the difference window
// and builds one data word, its nibble code and the count of differences used.
// ----------------------------------------------------------------------------
module s2fe_pack (
	input  wire s2fe_pkg::diff_win_t   win,
	output logic [31:0]                word,
	output logic [1:0]                 code,
	output logic [s2fe_pkg::CNT_W-1:0] used
);
	import s2fe_pkg::*;

	pack_class_t cls [WINDOW_DIFFS];
	pack_class_t top_cls;

	// Class of each difference from its magnitude.
	always_comb begin
		logic [31:0] mag;
		for (int k = 0; k < WINDOW_DIFFS; k++) begin
			mag = win[k][31] ? (32'd0 - win[k]) : win[k];
			if (mag <= LIM_7X4) begin
				cls[k] = PK_7X4;
			end else if (mag <= LIM_6X5) begin
				cls[k] = PK_6X5;
			end else if (mag <= LIM_5X6) begin
				cls[k] = PK_5X6;
			end else if (mag <= LIM_4X8) begin
				cls[k] = PK_4X8;
			end else if (mag <= LIM_3X10) begin
				cls[k] = PK_3X10;
			end else if (mag <= LIM_2X15) begin
				cls[k] = PK_2X15;
			end else begin
				cls[k] = PK_1X30;
			end
		end
	end

	// Widest class over the window.
	always_comb begin
		top_cls = PK_7X4;
		for (int k = 0; k < WINDOW_DIFFS; k++) begin
			if (cls[k] > top_cls) begin
				top_cls = cls[k];
			end
		end
	end

	// Word layout per class, oldest difference in the high bits.
	always_comb begin
		unique case (top_cls)
			PK_7X4: begin
				word = {2'd2, 2'b00, win[0][3:0], win[1][3:0], win[2][3:0], win[3][3:0],
					win[4][3:0], win[5][3:0], win[6][3:0]};
				code = NIB_SMALL;
				used = CNT_W'(7);
			end
			PK_6X5: begin
				word = {2'd1, win[0][4:0], win[1][4:0], win[2][4:0], win[3][4:0],
					win[4][4:0], win[5][4:0]};
				code = NIB_SMALL;
				used = CNT_W'(6);
			end
			PK_5X6: begin
				word = {2'd0, win[0][5:0], win[1][5:0], win[2][5:0], win[3][5:0],
					win[4][5:0]};
				code = NIB_SMALL;
				used = CNT_W'(5);
			end
			PK_4X8: begin
				word = {win[0][7:0], win[1][7:0], win[2][7:0], win[3][7:0]};
				code = NIB_4X8;
				used = CNT_W'(4);
			end
			PK_3X10: begin
				word = {2'd3, win[0][9:0], win[1][9:0], win[2][9:0]};
				code = NIB_DNIB;
				used = CNT_W'(3);
			end
			PK_2X15: begin
				word = {2'd2, win[0][14:0], win[1][14:0]};
				code = NIB_DNIB;
				used = CNT_W'(2);
			end
			PK_1X30: begin
				word = {2'd1, win[0][29:0]};
				code = NIB_DNIB;
				used = CNT_W'(1);
			end
			default: begin
				word = '0;
				code = NIB_NONE;
				used = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/s2fe_outq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Steim2 output queue
// Small result queue that decouples frame emission from the output stall.
// ----------------------------------------------------------------------------
module s2fe_outq (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             push,
	input  wire s2fe_pkg::out_item_t        push_item,
	input  wire                             pop,
	output logic                            head_valid,
	output s2fe_pkg::out_item_t             head_item,
	output logic [s2fe_pkg::OUTQ_CNT_W-1:0] fill
);
	import s2fe_pkg::*;

	out_item_t             slots_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_ptr_q;
	logic [OUTQ_PTR_W-1:0] rd_ptr_q;
	logic [OUTQ_CNT_W-1:0] fill_q;
	logic                  do_pop;

	assign do_pop     = pop && (fill_q != '0);
	assign head_valid = (fill_q != '0);
	assign head_item  = slots_q[rd_ptr_q];
	assign fill       = fill_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && do_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/steim2_frame_encoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Steim2 frame encoder
// Turns 32-bit samples into 16-word Steim2 frames, one word per transfer.
// ----------------------------------------------------------------------------
// A sample that does not fill the difference window is only added to it; a
// sample that fills it is followed by the pack state, which packs one data
// word into the frame memory. When a frame is complete the block emits its 16
// words, one word per cycle while the output queue has room, read from the
// single-port frame memory, and takes no new item until the last word is
// issued. A flush packs one word per cycle until the record is closed, and
// emits each frame it completes. Output words pass through a four-entry queue,
// so the output may stall without losing data.
module steim2_frame_encoder (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire s2fe_pkg::in_item_t in_item,
	output logic                   out_valid,
	input  wire                    out_stall,
	output s2fe_pkg::out_item_t    out_item,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire                    cfg_data
);
	import s2fe_pkg::*;

	state_t                state_q, state_d;
	in_item_t              in_s1;
	logic                  in_v_s1;
	logic                  swap_q;
	logic [31:0]           prev_q;
	diff_win_t             win_q;
	diff_win_t             win_shift;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      cnt_after;
	logic [31:0]           nib_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  first_q;
	logic                  flush_q;
	logic                  final_q;
	logic [SLOT_W-1:0]     emit_idx_q;
	logic [31:0]           frame_mem [FRAME_WORDS];

	logic                  consume, do_init, do_push, start_flush, do_pack;
	logic                  issue, emit_done, issue_ok;
	logic [31:0]           pk_word;
	logic [1:0]            pk_code;
	logic [CNT_W-1:0]      pk_used;

	logic                  rd_v_q;
	logic [31:0]           rd_data_q;
	logic [SLOT_W-1:0]     rd_idx_q;
	logic [31:0]           rd_nib_q;
	logic                  rd_first_q;
	logic                  rd_last_q;
	logic [31:0]           rd_word;
	out_item_t             push_item;
	logic [OUTQ_CNT_W-1:0] q_fill;

	assign cfg_ready = 1'b1;
	assign in_stall  = in_v_s1 && !consume;

	s2fe_pack u_pack (
		.win  (win_q),
		.word (pk_word),
		.code (pk_code),
		.used (pk_used)
	);

	// Window after consuming the packed differences.
	always_comb begin
		logic [CNT_W:0] src;
		for (int k = 0; k < WINDOW_DIFFS; k++) begin
			src = (CNT_W + 1)'(k) + {1'b0, pk_used};
			win_shift[k] = (src < (CNT_W + 1)'(WINDOW_DIFFS)) ? win_q[src[CNT_W-1:0]] : '0;
		end
		cnt_after = (cnt_q > pk_used) ? (cnt_q - pk_used) : '0;
	end

	// Keep the queue from overflowing, counting the read in flight.
	assign issue_ok = ((OUTQ_CNT_W + 1)'(q_fill) + (OUTQ_CNT_W + 1)'(rd_v_q))
		< (OUTQ_CNT_W + 1)'(OUTQ_DEPTH - 1);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control strobes.
	always_comb begin
		state_d     = state_q;
		consume     = 1'b0;
		do_init     = 1'b0;
		do_push     = 1'b0;
		start_flush = 1'b0;
		do_pack     = 1'b0;
		issue       = 1'b0;
		emit_done   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_v_s1) begin
					priority if (in_s1.opcode == OP_FLUSH) begin
						consume = 1'b1;
						if (slot_q != '0) begin
							start_flush = 1'b1;
							state_d     = ST_PACK;
						end
					end else if (in_s1.start_record || slot_q == '0) begin
						// An open record is closed first; the sample stays held.
						if (slot_q != '0) begin
							start_flush = 1'b1;
							state_d     = ST_PACK;
						end else begin
							consume = 1'b1;
							do_init = 1'b1;
						end
					end else begin
						consume = 1'b1;
						do_push = 1'b1;
						if (cnt_q == CNT_W'(WINDOW_DIFFS - 1)) begin
							state_d = ST_PACK;
						end
					end
				end
			end
			ST_PACK: begin
				do_pack = 1'b1;
				if (slot_q == SLOT_W'(FRAME_WORDS - 1)) begin
					state_d = ST_EMIT;
				end else if (!flush_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (issue_ok) begin
					issue = 1'b1;
					if (emit_idx_q == SLOT_W'(FRAME_WORDS - 1)) begin
						emit_done = 1'b1;
						state_d   = (flush_q && !final_q) ? ST_PACK : ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			in_v_s1 <= 1'b1;
		end else if (consume) begin
			in_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_s1 <= in_item;
		end
	end

	// Byte order register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			swap_q <= cfg_data;
		end
	end

	// Encoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			win_q      <= '0;
			cnt_q      <= '0;
			nib_q      <= '0;
			slot_q     <= '0;
			first_q    <= 1'b1;
			flush_q    <= 1'b0;
			final_q    <= 1'b0;
			emit_idx_q <= '0;
		end else begin
			if (start_flush) begin
				flush_q <= 1'b1;
			end
			priority if (do_init) begin
				win_q    <= {{(WINDOW_DIFFS - 1){32'd0}}, in_s1.sample};
				cnt_q    <= CNT_W'(1);
				prev_q   <= in_s1.sample;
				nib_q    <= '0;
				slot_q   <= SLOT_W'(3);
				first_q  <= 1'b1;
			end else if (do_push) begin
				for (int k = 0; k < WINDOW_DIFFS; k++) begin
					if (cnt_q == CNT_W'(k)) begin
						win_q[k] <= in_s1.sample - prev_q;
					end
				end
				cnt_q  <= cnt_q + 1'b1;
				prev_q <= in_s1.sample;
			end else if (do_pack) begin
				win_q <= win_shift;
				cnt_q <= cnt_after;
				nib_q <= nib_q | (32'(pk_code) << (5'd30 - {slot_q, 1'b0}));
				if (slot_q == SLOT_W'(FRAME_WORDS - 1)) begin
					slot_q     <= SLOT_W'(1);
					final_q    <= flush_q && (cnt_after == '0);
					emit_idx_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end else if (issue) begin
				emit_idx_q <= emit_idx_q + 1'b1;
				if (emit_done) begin
					nib_q <= '0;
					if (final_q) begin
						// Record closed: back to the no-record state.
						slot_q  <= '0;
						first_q <= 1'b1;
						cnt_q   <= '0;
						win_q   <= '0;
						flush_q <= 1'b0;
						final_q <= 1'b0;
					end else begin
						first_q <= 1'b0;
					end
				end
			end
		end
	end

	// Frame memory: packed words and the first sample are written, words read.
	always_ff @(posedge clk) begin
		if (do_init) begin
			frame_mem[1] <= in_s1.sample;
		end else if (do_pack) begin
			frame_mem[slot_q] <= pk_word;
		end
		if (issue) begin
			rd_data_q  <= frame_mem[emit_idx_q];
			rd_idx_q   <= emit_idx_q;
			rd_nib_q   <= nib_q;
			rd_first_q <= first_q;
			rd_last_q  <= final_q && emit_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q <= 1'b0;
		end else begin
			rd_v_q <= issue;
		end
	end

	// Word select: W0 carries the nibble codes, W2 of frame 0 is zero.
	always_comb begin
		logic [31:0] raw;
		priority if (rd_idx_q == '0) begin
			raw = rd_nib_q;
		end else if (rd_first_q && rd_idx_q == SLOT_W'(2)) begin
			raw = '0;
		end else begin
			raw = rd_data_q;
		end
		rd_word = swap_q ? byte_rev(raw) : raw;
	end

	assign push_item = '{
		word:           rd_word,
		word_index:     rd_idx_q,
		last_of_frame:  (rd_idx_q == SLOT_W'(FRAME_WORDS - 1)),
		last_of_record: rd_last_q
	};

	s2fe_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (rd_v_q),
		.push_item  (push_item),
		.pop        (!out_stall),
		.head_valid (out_valid),
		.head_item  (out_item),
		.fill       (q_fill)
	);

`ifndef SYNTHESIS
	// A sample-driven pack only happens on a full window.
	a_pack_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PACK && !flush_q) |-> (cnt_q == CNT_W'(WINDOW_DIFFS)))
		else $error("pack outside flush without a full window");

	// The closing frame only exists inside a flush.
	a_final_flush: assert property (@(posedge clk) disable iff (!arst_n)
		final_q |-> flush_q)
		else $error("record end marked outside a flush");

	// During emission the next data slot is W1.
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (slot_q == SLOT_W'(1)))
		else $error("slot not reset for emission");

	// A read is only issued with room in the output queue.
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_q |-> (q_fill < OUTQ_CNT_W'(OUTQ_DEPTH)))
		else $error("output queue overflow");
`endif

endmodule
`default_nettype wire

@@ sim/steim2_checker.sv @@
// ----------------------------------------------------------------------------
// Steim2 frame encoder checker
// Watches the input, output and register channels of the encoder, predicts
// every frame word from accepted items and compares each output transfer with
// the oldest predicted word.
// ----------------------------------------------------------------------------
module steim2_checker (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	input  wire                     in_stall,
	input  wire s2fe_pkg::in_item_t  in_item,
	input  wire                     out_valid,
	input  wire                     out_stall,
	input  wire s2fe_pkg::out_item_t out_item,
	input  wire                     cfg_valid,
	input  wire                     cfg_ready,
	input  wire                     cfg_data,
	output int                      fail_count,
	output int                      words_pending
);
	import s2fe_pkg::*;

	// Predicted encoder state.
	logic        swap_q;
	logic [31:0] prev_q;
	logic [31:0] win_q [WINDOW_DIFFS];
	int          win_cnt;
	logic [31:0] frame_q [FRAME_WORDS];
	logic [31:0] nib_q;
	int          slot_q;

	out_item_t frame_word_q [$];

	assign words_pending = frame_word_q.size();

	// Queue the 16 words of the finished frame.
	task automatic push_frame();
		out_item_t o;
		for (int i = 0; i < FRAME_WORDS; i++) begin
			o.word = (i == 0) ? nib_q : frame_q[i];
			if (swap_q)
				o.word = {o.word[7:0], o.word[15:8], o.word[23:16], o.word[31:24]};
			o.word_index = i[SLOT_W-1:0];
			o.last_of_frame = (i == FRAME_WORDS - 1);
			o.last_of_record = 1'b0;
			frame_word_q.push_back(o);
		end
		slot_q = 1;
		nib_q = '0;
	endtask

	// Pack one data word from the oldest differences of the window.
	task automatic pack_data_word();
		logic [31:0] maxmag, m, w, mask;
		int n, bits;
		logic [1:0] code, dnib;
		maxmag = '0;
		for (int k = 0; k < WINDOW_DIFFS; k++) begin
			m = win_q[k][31] ? -win_q[k] : win_q[k];
			if (m > maxmag)
				maxmag = m;
		end
		if (maxmag <= LIM_7X4) begin
			n = 7; bits = 4; code = NIB_SMALL; dnib = 2'd2;
		end else if (maxmag <= LIM_6X5) begin
			n = 6; bits = 5; code = NIB_SMALL; dnib = 2'd1;
		end else if (maxmag <= LIM_5X6) begin
			n = 5; bits = 6; code = NIB_SMALL; dnib = 2'd0;
		end else if (maxmag <= LIM_4X8) begin
			n = 4; bits = 8; code = NIB_4X8; dnib = 2'd0;
		end else if (maxmag <= LIM_3X10) begin
			n = 3; bits = 10; code = NIB_DNIB; dnib = 2'd3;
		end else if (maxmag <= LIM_2X15) begin
			n = 2; bits = 15; code = NIB_DNIB; dnib = 2'd2;
		end else begin
			n = 1; bits = 30; code = NIB_DNIB; dnib = 2'd1;
		end
		mask = (32'd1 << bits) - 32'd1;
		w = {dnib, 30'd0};
		for (int k = 0; k < n; k++)
			w |= (win_q[k] & mask) << (bits * (n - 1 - k));
		for (int k = 0; k < WINDOW_DIFFS; k++)
			win_q[k] = (k + n < WINDOW_DIFFS) ? win_q[k + n] : 32'd0;
		win_cnt = (win_cnt > n) ? win_cnt - n : 0;
		slot_q = slot_q % FRAME_WORDS;
		frame_q[slot_q] = w;
		nib_q |= 32'(code) << (30 - 2 * slot_q);
		slot_q++;
		if (slot_q >= FRAME_WORDS)
			push_frame();
	endtask

	// Close the open record, padding with zero differences.
	task automatic close_record();
		int start_size;
		out_item_t o;
		start_size = frame_word_q.size();
		if (slot_q == 0)
			return;
		while (win_cnt > 0) begin
			for (int k = win_cnt; k < WINDOW_DIFFS; k++)
				win_q[k] = '0;
			pack_data_word();
		end
		if (frame_word_q.size() == start_size || slot_q != 1) begin
			do begin
				for (int k = 0; k < WINDOW_DIFFS; k++)
					win_q[k] = '0;
				win_cnt = 0;
				pack_data_word();
			end while (slot_q != 1);
		end
		o = frame_word_q[$];
		o.last_of_record = 1'b1;
		frame_word_q[$] = o;
		slot_q = 0;
		win_cnt = 0;
		nib_q = '0;
		for (int k = 0; k < WINDOW_DIFFS; k++)
			win_q[k] = '0;
	endtask

	// Predict the words caused by one accepted input item.
	task automatic encode_item(input in_item_t it);
		if (it.opcode == OP_FLUSH) begin
			close_record();
			return;
		end
		if (it.start_record || slot_q == 0) begin
			close_record();
			frame_q[0] = '0;
			frame_q[1] = it.sample;
			frame_q[2] = '0;
			slot_q = 3;
			nib_q = '0;
			win_cnt = 0;
			for (int k = 0; k < WINDOW_DIFFS; k++)
				win_q[k] = '0;
			prev_q = '0;
		end
		if (win_cnt < WINDOW_DIFFS)
			win_q[win_cnt] = it.sample - prev_q;
		win_cnt++;
		prev_q = it.sample;
		if (win_cnt >= WINDOW_DIFFS) begin
			win_cnt = WINDOW_DIFFS;
			pack_data_word();
		end
	endtask

	// Compare one output transfer with the oldest predicted word.
	task automatic check_word(input out_item_t got);
		out_item_t exp_w;
		if (frame_word_q.size() == 0) begin
			$error("unexpected word %h index %0d", got.word, got.word_index);
			fail_count++;
			return;
		end
		exp_w = frame_word_q.pop_front();
		if (got.word !== exp_w.word) begin
			$error("word: expected %h, got %h", exp_w.word, got.word);
			fail_count++;
		end
		if (got.word_index !== exp_w.word_index) begin
			$error("word_index: expected %0d, got %0d", exp_w.word_index, got.word_index);
			fail_count++;
		end
		if (got.last_of_frame !== exp_w.last_of_frame) begin
			$error("last_of_frame: expected %b, got %b", exp_w.last_of_frame,
				got.last_of_frame);
			fail_count++;
		end
		if (got.last_of_record !== exp_w.last_of_record) begin
			$error("last_of_record: expected %b, got %b", exp_w.last_of_record,
				got.last_of_record);
			fail_count++;
		end
	endtask

	// Track every transfer on the three channels.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q = 1'b1;
			prev_q = '0;
			win_cnt = 0;
			nib_q = '0;
			slot_q = 0;
			fail_count = 0;
			for (int k = 0; k < WINDOW_DIFFS; k++)
				win_q[k] = '0;
			for (int k = 0; k < FRAME_WORDS; k++)
				frame_q[k] = '0;
			frame_word_q.delete();
		end else begin
			if (out_valid && !out_stall)
				check_word(out_item);
			if (cfg_valid && cfg_ready)
				swap_q = cfg_data;
			if (in_valid && !in_stall)
				encode_item(in_item);
		end
	end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Steim2 frame encoder testbench
// Drives directed and random sample streams, flushes and record starts under
// random sender gaps and receiver stalls, switches the byte-swap register
// between phases and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
	import s2fe_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_LEN   = 300;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;
	logic      cfg_valid;
	logic      cfg_ready;
	logic      cfg_data;
	int        fail_count;
	int        words_pending;
	int        hold_cycles;
	logic      hold_go;
	logic      hold_done;
	int        idle_cycles = 0;
	logic [31:0] last_sample;

	steim2_frame_encoder u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	steim2_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .words_pending(words_pending)
	);

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver stall pattern, with one long hold-off once it is requested.
	initial begin
		out_stall = 1'b0;
		hold_cycles = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_cycles = HOLD_LEN;
				hold_done = 1'b1;
			end
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				case ($urandom_range(0, 3))
					0: out_stall <= ($urandom_range(0, 1) == 1);
					1: out_stall <= 1'b0;
					2: out_stall <= ($urandom_range(0, 7) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one item and hold it until its transfer.
	task automatic send_item(input logic op, input logic [31:0] smp, input logic st);
		in_item.opcode <= op;
		in_item.sample <= smp;
		in_item.start_record <= st;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		last_sample = smp;
	endtask

	task automatic idle_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Write the byte-swap register once the encoder is drained.
	task automatic set_swap(input logic v);
		in_valid <= 1'b0;
		while (words_pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Previous sample plus a difference of a random class, or a random word.
	function automatic logic [31:0] next_sample(input logic [31:0] prev);
		logic [31:0] d;
		case ($urandom_range(0, 7))
			0: d = $urandom_range(0, 14) - 7;
			1: d = $urandom_range(0, 30) - 15;
			2: d = $urandom_range(0, 62) - 31;
			3: d = $urandom_range(0, 254) - 127;
			4: d = $urandom_range(0, 1022) - 511;
			5: d = $urandom_range(0, 32766) - 16383;
			6: return $urandom();
			default: d = $urandom_range(0, 6) - 3;
		endcase
		return prev + d;
	endfunction

	// Bursty random stream of records, mostly samples.
	task automatic random_phase(input int count);
		int burst;
		int r;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
				burst = $urandom_range(1, 20);
			end
			burst--;
			r = $urandom_range(0, 99);
			if (r < 3)
				send_item(OP_FLUSH, $urandom(), 1'($urandom_range(0, 1)));
			else if (r < 6)
				send_item(OP_SAMPLE, $urandom(), 1'b1);
			else
				send_item(OP_SAMPLE, next_sample(last_sample), 1'b0);
		end
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		hold_go = 1'b0;
		last_sample = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: flush with nothing open, extremes, every class.
		send_item(OP_FLUSH, 32'h0, 1'b0);
		send_item(OP_SAMPLE, 32'h7fffffff, 1'b0);
		send_item(OP_SAMPLE, 32'h80000000, 1'b0);
		send_item(OP_SAMPLE, 32'h0, 1'b0);
		send_item(OP_SAMPLE, 32'hffffffff, 1'b0);
		send_item(OP_SAMPLE, 32'h0, 1'b0);
		send_item(OP_SAMPLE, 32'd7, 1'b0);
		send_item(OP_SAMPLE, 32'd0, 1'b0);
		send_item(OP_SAMPLE, 32'd15, 1'b1);
		send_item(OP_SAMPLE, 32'd0, 1'b0);
		send_item(OP_SAMPLE, 32'd31, 1'b0);
		send_item(OP_SAMPLE, 32'd158, 1'b0);
		send_item(OP_SAMPLE, 32'd669, 1'b0);
		send_item(OP_SAMPLE, 32'd17052, 1'b0);
		send_item(OP_SAMPLE, 32'd0, 1'b0);
		send_item(OP_FLUSH, 32'hffffffff, 1'b1);
		send_item(OP_FLUSH, 32'h0, 1'b0);
		send_item(OP_SAMPLE, 32'h12345678, 1'b1);
		send_item(OP_FLUSH, 32'h0, 1'b0);
		set_swap(1'b0);
		send_item(OP_SAMPLE, 32'hdeadbeef, 1'b0);
		for (int i = 0; i < 5; i++)
			send_item(OP_SAMPLE, 32'hdeadbeef + 32'(i), 1'b0);
		send_item(OP_FLUSH, 32'h0, 1'b0);

		// Random phases across both register settings.
		random_phase(150);
		set_swap(1'b1);
		hold_go = 1'b1;
		random_phase(150);
		set_swap(1'b0);
		random_phase(130);
		send_item(OP_FLUSH, 32'h0, 1'b0);
		in_valid <= 1'b0;

		while (words_pending != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
